// ----- hw/rtl/ppts_pkg.sv -----
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared types, codes and defaults of the preemptive priority task scheduler.
// ----------------------------------------------------------------------------
package ppts_pkg;

    // Default sizing
    localparam int MAX_TASKS_DEF = 16;
    localparam int PRIO_BITS_DEF = 4;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int TASK_W   = 4;
    localparam int RND_W    = 16;
    localparam int KIND_W   = 2;
    localparam int ERR_W    = 3;
    localparam int TICK_W   = 16;
    localparam int TCNT_W   = 5;
    localparam int PTAB_W   = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 64;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BLOCKED = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READY   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_OTHER   = 2'd3;

    // Message kinds
    localparam logic [KIND_W-1:0] MSG_PAUSE = 2'd0;
    localparam logic [KIND_W-1:0] MSG_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] MSG_ERROR = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NO_RUNNING   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NOT_RUNNING  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_EXECUTING    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NOT_BLOCKED  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_ILLEGAL      = 3'd4;

    // Task status codes
    localparam logic [1:0] TS_BLOCKED = 2'd0;
    localparam logic [1:0] TS_READY   = 2'd1;
    localparam logic [1:0] TS_PAUSED  = 2'd2;
    localparam logic [1:0] TS_RUNNING = 2'd3;

    // Configuration register indices
    localparam logic [CFG_IDX_W-1:0] CFG_EXEC_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_TABLE   = 2'd3;

    // Reset values
    localparam logic [TICK_W-1:0] EXEC_TICKS_RST   = 16'd10;
    localparam logic [TICK_W-1:0] PERIOD_TICKS_RST = 16'd100;
    localparam logic [TCNT_W-1:0] TASK_COUNT_RST   = 5'd16;
    localparam logic [PTAB_W-1:0] PRIO_TABLE_RST   = '0;

    // Input transaction
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TASK_W-1:0] task_id;
        logic [RND_W-1:0]  random_value;
    } in_item_t;

    // Output transaction
    typedef struct packed {
        logic [KIND_W-1:0] message_kind;
        logic [TASK_W-1:0] target_task;
        logic [ERR_W-1:0]  error_code;
    } out_item_t;

endpackage

// ----- hw/rtl/ppts_mod_unit.sv -----
// ----------------------------------------------------------------------------
// ppts_mod_unit
// Iterative remainder unit: one dividend bit per cycle, restoring form.
// ----------------------------------------------------------------------------
module ppts_mod_unit
    import ppts_pkg::*;
#(
    parameter int DIVIDEND_W = RND_W,
    parameter int DIVISOR_W  = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CTR_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CTR_W-1:0]      ctr_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W:0]    trial;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[DIVISOR_W-1:0];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ctr_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            ctr_reg  <= CTR_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            ctr_reg <= ctr_reg - 1'b1;
            if (ctr_reg == CTR_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- hw/rtl/preemptive_priority_task_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// preemptive_priority_task_scheduler_core
// Fixed-priority preemptive task scheduler with random tie breaking.
// ----------------------------------------------------------------------------
//  Channel | Dir | Signals                         | Transaction when
//  --------+-----+---------------------------------+--------------------------
//  in      | in  | in_valid, in_ready, in_data     | in_valid && in_ready
//  out     | out | out_valid, out_ready, out_data  | out_valid && out_ready
//  cfg     | in  | cfg_we, cfg_index, cfg_data     | cfg_we
//
//  One transaction at a time. A tick that ends execution scans the task
//  status memory, and if any task is eligible it runs the remainder unit
//  and scans the memory again. Reset clears all control state; the status
//  memory needs no clearing pass (per-entry valid bits). A stalled output
//  holds one result while the next transaction is accepted and worked on.
// ----------------------------------------------------------------------------
module preemptive_priority_task_scheduler_core
    import ppts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = ($clog2(MAX_TASKS + 1) > TCNT_W) ? $clog2(MAX_TASKS + 1) : TCNT_W;
    localparam int SH_W  = $clog2(PRIO_BITS * MAX_TASKS + 1);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_CHECK  = 8'b0000_0100,
        ST_PAUSE  = 8'b0000_1000,
        ST_SCAN1  = 8'b0001_0000,
        ST_DIVIDE = 8'b0010_0000,
        ST_SCAN2  = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    // Priority of a task from the packed table; bits beyond the table read zero
    function automatic logic [PRIO_BITS-1:0] prio_of(input logic [PTAB_W-1:0] tbl,
                                                     input logic [IDX_W-1:0] t);
        logic [PTAB_W-1:0] sh;
        begin
            sh = tbl >> (SH_W'(t) * SH_W'(PRIO_BITS));
            return sh[PRIO_BITS-1:0];
        end
    endfunction

    // Configuration registers
    logic [TICK_W-1:0]    exec_ticks_reg;
    logic [TICK_W-1:0]    period_ticks_reg;
    logic [TCNT_W-1:0]    task_count_reg;
    logic [PTAB_W-1:0]    prio_table_reg;

    // Control state
    state_t               state_reg, state_next;
    logic                 running_valid_reg, running_valid_next;
    logic [IDX_W-1:0]     running_task_reg, running_task_next;
    logic                 executing_reg, executing_next;
    logic [TICK_W-1:0]    countdown_reg, countdown_next;
    logic [CNT_W-1:0]     issue_idx_reg, issue_idx_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 any_reg, any_next;
    logic [PRIO_BITS-1:0] best_reg, best_next;
    logic [CNT_W-1:0]     match_cnt_reg, match_cnt_next;
    logic [CNT_W-1:0]     seen_reg, seen_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload registers
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [TASK_W-1:0]    id_reg, id_next;
    logic [RND_W-1:0]     rnd_reg, rnd_next;
    out_item_t            res_reg, res_next;
    out_item_t            out_data_reg, out_data_next;

    // Status memory with per-entry valid bits
    logic [1:0]           status_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] status_vld_reg;
    logic [1:0]           rd_data_reg;
    logic                 rd_ok_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [1:0]           mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;

    // Remainder unit
    logic                 div_start;
    logic                 div_done;
    logic [CNT_W-1:0]     div_rem;

    // Derived values
    logic [CNT_W-1:0]     eff_cnt;
    logic [CNT_W-1:0]     tc_ext;
    logic [CNT_W-1:0]     id_ext;
    logic [CNT_W-1:0]     run_ext;
    logic [CNT_W-1:0]     rd_idx_ext;
    logic [IDX_W-1:0]     id_addr;
    logic                 is_running;
    logic                 in_use;
    logic [1:0]           rd_status;
    logic                 rd_elig;
    logic [PRIO_BITS-1:0] rd_prio;
    logic [TICK_W-1:0]    run_reload;
    logic                 scan_end;

    // Effective task count, index views
    always_comb
    begin
        tc_ext     = CNT_W'(task_count_reg);
        eff_cnt    = (tc_ext > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : tc_ext;
        id_ext     = CNT_W'(id_reg);
        run_ext    = CNT_W'(running_task_reg);
        rd_idx_ext = CNT_W'(rd_idx_reg);
        id_addr    = id_ext[IDX_W-1:0];
        is_running = running_valid_reg && (id_ext == run_ext);
        in_use     = id_ext < eff_cnt;
        rd_status  = rd_ok_reg ? rd_data_reg : TS_BLOCKED;
        rd_elig    = (rd_status == TS_READY) || (rd_status == TS_PAUSED);
        rd_prio    = prio_of(prio_table_reg, rd_idx_reg);
        run_reload = (period_ticks_reg > exec_ticks_reg) ?
                     (period_ticks_reg - exec_ticks_reg) : TICK_W'(1);
        scan_end   = (issue_idx_reg >= eff_cnt) && !rd_vld_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next         = state_reg;
        running_valid_next = running_valid_reg;
        running_task_next  = running_task_reg;
        executing_next     = executing_reg;
        countdown_next     = countdown_reg;
        issue_idx_next     = issue_idx_reg;
        rd_vld_next        = 1'b0;
        rd_idx_next        = rd_idx_reg;
        any_next           = any_reg;
        best_next          = best_reg;
        match_cnt_next     = match_cnt_reg;
        seen_next          = seen_reg;
        cmd_next           = cmd_reg;
        id_next            = id_reg;
        rnd_next           = rnd_reg;
        res_next           = res_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_data_next      = out_data_reg;
        mem_we             = 1'b0;
        mem_waddr          = id_addr;
        mem_wdata          = TS_BLOCKED;
        mem_re             = 1'b0;
        mem_raddr          = id_addr;
        div_start          = 1'b0;

        // Scan read issue, shared by both passes
        if (((state_reg == ST_SCAN1) || (state_reg == ST_SCAN2)) && (issue_idx_reg < eff_cnt))
        begin
            mem_re         = 1'b1;
            mem_raddr      = issue_idx_reg[IDX_W-1:0];
            rd_vld_next    = 1'b1;
            rd_idx_next    = issue_idx_reg[IDX_W-1:0];
            issue_idx_next = issue_idx_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_data.command;
                    id_next    = in_data.task_id;
                    rnd_next   = in_data.random_value;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                res_next.target_task = '0;
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (countdown_reg > TICK_W'(1))
                        begin
                            countdown_next = countdown_reg - 1'b1;
                            state_next     = ST_IDLE;
                        end
                        else if (!executing_reg)
                        begin
                            executing_next = 1'b1;
                            countdown_next = exec_ticks_reg;
                            state_next     = running_valid_reg ? ST_PAUSE : ST_IDLE;
                        end
                        else
                        begin
                            issue_idx_next = '0;
                            any_next       = 1'b0;
                            best_next      = '0;
                            match_cnt_next = '0;
                            state_next     = ST_SCAN1;
                        end
                    end
                    CMD_BLOCKED:
                    begin
                        res_next.message_kind = MSG_ERROR;
                        if (!running_valid_reg)
                        begin
                            res_next.error_code = ERR_NO_RUNNING;
                            state_next          = ST_EMIT;
                        end
                        else if (!is_running)
                        begin
                            res_next.error_code = ERR_NOT_RUNNING;
                            state_next          = ST_EMIT;
                        end
                        else if (executing_reg)
                        begin
                            res_next.error_code = ERR_EXECUTING;
                            state_next          = ST_EMIT;
                        end
                        else
                        begin
                            mem_we             = 1'b1;
                            mem_wdata          = TS_BLOCKED;
                            running_valid_next = 1'b0;
                            executing_next     = 1'b1;
                            countdown_next     = exec_ticks_reg;
                            state_next         = ST_IDLE;
                        end
                    end
                    CMD_READY:
                    begin
                        res_next.message_kind = MSG_ERROR;
                        res_next.error_code   = ERR_NOT_BLOCKED;
                        if (is_running)
                        begin
                            mem_we             = 1'b1;
                            mem_wdata          = TS_READY;
                            running_valid_next = 1'b0;
                            executing_next     = 1'b1;
                            countdown_next     = exec_ticks_reg;
                            state_next         = ST_IDLE;
                        end
                        else if (!in_use)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = id_addr;
                            state_next = ST_CHECK;
                        end
                    end
                    default:
                    begin
                        res_next.message_kind = MSG_ERROR;
                        res_next.error_code   = ERR_ILLEGAL;
                        state_next            = ST_EMIT;
                    end
                endcase
            end

            // Ready event from a task in use: status of that task now read
            ST_CHECK:
            begin
                if (rd_status != TS_BLOCKED)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = TS_READY;
                    state_next = ST_IDLE;
                    if (!running_valid_reg && !executing_reg)
                    begin
                        executing_next = 1'b1;
                        countdown_next = exec_ticks_reg;
                    end
                    else if (running_valid_reg && !executing_reg &&
                             (prio_of(prio_table_reg, running_task_reg) <
                              prio_of(prio_table_reg, id_addr)))
                    begin
                        executing_next = 1'b1;
                        countdown_next = exec_ticks_reg;
                        state_next     = ST_PAUSE;
                    end
                end
            end

            // Pause the running task and report it
            ST_PAUSE:
            begin
                mem_we                = 1'b1;
                mem_waddr             = running_task_reg;
                mem_wdata             = TS_PAUSED;
                running_valid_next    = 1'b0;
                res_next.message_kind = MSG_PAUSE;
                res_next.target_task  = run_ext[TASK_W-1:0];
                res_next.error_code   = ERR_NONE;
                state_next            = ST_EMIT;
            end

            // First pass: top priority and number of eligible tasks at it
            ST_SCAN1:
            begin
                if (rd_vld_reg && rd_elig)
                begin
                    if (!any_reg || (rd_prio > best_reg))
                    begin
                        best_next      = rd_prio;
                        any_next       = 1'b1;
                        match_cnt_next = CNT_W'(1);
                    end
                    else if (rd_prio == best_reg)
                    begin
                        match_cnt_next = match_cnt_reg + 1'b1;
                    end
                end
                if (scan_end)
                begin
                    if (any_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        executing_next = 1'b0;
                        countdown_next = run_reload;
                        state_next     = ST_IDLE;
                    end
                end
            end

            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    issue_idx_next = '0;
                    seen_next      = '0;
                    state_next     = ST_SCAN2;
                end
            end

            // Second pass: run the picked entry among top-priority tasks
            ST_SCAN2:
            begin
                if (rd_vld_reg && rd_elig && (rd_prio == best_reg))
                begin
                    if (seen_reg == div_rem)
                    begin
                        mem_we                = 1'b1;
                        mem_waddr             = rd_idx_reg;
                        mem_wdata             = TS_RUNNING;
                        running_valid_next    = 1'b1;
                        running_task_next     = rd_idx_reg;
                        res_next.message_kind = MSG_RUN;
                        res_next.target_task  = rd_idx_ext[TASK_W-1:0];
                        res_next.error_code   = ERR_NONE;
                        executing_next        = 1'b0;
                        countdown_next        = run_reload;
                        rd_vld_next           = 1'b0;
                        state_next            = ST_EMIT;
                    end
                    else
                    begin
                        seen_next = seen_reg + 1'b1;
                    end
                end
                else if (scan_end)
                begin
                    executing_next = 1'b0;
                    countdown_next = run_reload;
                    state_next     = ST_IDLE;
                end
            end

            // Hand result to the output register once it is free
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            running_valid_reg <= 1'b0;
            running_task_reg  <= '0;
            executing_reg     <= 1'b1;
            countdown_reg     <= EXEC_TICKS_RST;
            issue_idx_reg     <= '0;
            rd_vld_reg        <= 1'b0;
            any_reg           <= 1'b0;
            best_reg          <= '0;
            match_cnt_reg     <= '0;
            seen_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            running_valid_reg <= running_valid_next;
            running_task_reg  <= running_task_next;
            executing_reg     <= executing_next;
            countdown_reg     <= countdown_next;
            issue_idx_reg     <= issue_idx_next;
            rd_vld_reg        <= rd_vld_next;
            any_reg           <= any_next;
            best_reg          <= best_next;
            match_cnt_reg     <= match_cnt_next;
            seen_reg          <= seen_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        rnd_reg      <= rnd_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        rd_idx_reg   <= rd_idx_next;
    end

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_ticks_reg   <= EXEC_TICKS_RST;
            period_ticks_reg <= PERIOD_TICKS_RST;
            task_count_reg   <= TASK_COUNT_RST;
            prio_table_reg   <= PRIO_TABLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXEC_TICKS:   exec_ticks_reg   <= cfg_data[TICK_W-1:0];
                CFG_PERIOD_TICKS: period_ticks_reg <= cfg_data[TICK_W-1:0];
                CFG_TASK_COUNT:   task_count_reg   <= cfg_data[TCNT_W-1:0];
                CFG_PRIO_TABLE:   prio_table_reg   <= cfg_data[PTAB_W-1:0];
                default:          task_count_reg   <= task_count_reg;
            endcase
        end
    end

    // Status memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            status_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= status_mem[mem_raddr];
        end
    end

    // Entry valid bits; an unwritten entry reads as blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_vld_reg <= '0;
            rd_ok_reg      <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                status_vld_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_ok_reg <= status_vld_reg[mem_raddr];
            end
        end
    end

    // Tie-break pick: random draw modulo the number of top-priority tasks
    ppts_mod_unit #(
        .DIVIDEND_W (RND_W),
        .DIVISOR_W  (CNT_W)
    ) u_mod (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend   (rnd_reg),
        .divisor    (match_cnt_reg),
        .done       (div_done),
        .remainder  (div_rem)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
